### rtl/core/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared widths, types and helpers for the rotation matrix to quaternion block
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int IO_W          = 18;
  localparam int OUT_MAX       = 131071;

  typedef struct packed {
    logic signed [IO_W-1:0] x_axis_x;
    logic signed [IO_W-1:0] x_axis_y;
    logic signed [IO_W-1:0] x_axis_z;
    logic signed [IO_W-1:0] y_axis_x;
    logic signed [IO_W-1:0] y_axis_y;
    logic signed [IO_W-1:0] y_axis_z;
    logic signed [IO_W-1:0] z_axis_x;
    logic signed [IO_W-1:0] z_axis_y;
    logic signed [IO_W-1:0] z_axis_z;
  } mat_t;

  // width of the unnormalised quaternion components
  function automatic int vec_w(input int frac);
    vec_w = ((frac > 19) ? frac : 19) + 3;
  endfunction

  // largest output magnitude
  function automatic int lim_val(input int frac);
    lim_val = (frac >= 17) ? OUT_MAX : (1 << frac);
  endfunction

endpackage

### rtl/core/rmq_if.sv
// ----------------------------------------------------------------------------
// rmq_in_if / rmq_out_if
// Request channels carrying a matrix in and a quaternion out
// ----------------------------------------------------------------------------
interface rmq_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [rmq_pkg::IO_W-1:0]    x_axis_x;
  logic signed [rmq_pkg::IO_W-1:0]    x_axis_y;
  logic signed [rmq_pkg::IO_W-1:0]    x_axis_z;
  logic signed [rmq_pkg::IO_W-1:0]    y_axis_x;
  logic signed [rmq_pkg::IO_W-1:0]    y_axis_y;
  logic signed [rmq_pkg::IO_W-1:0]    y_axis_z;
  logic signed [rmq_pkg::IO_W-1:0]    z_axis_x;
  logic signed [rmq_pkg::IO_W-1:0]    z_axis_y;
  logic signed [rmq_pkg::IO_W-1:0]    z_axis_z;

  modport source (output valid, x_axis_x, x_axis_y, x_axis_z, y_axis_x, y_axis_y,
                  y_axis_z, z_axis_x, z_axis_y, z_axis_z, input ready);
  modport sink   (input valid, x_axis_x, x_axis_y, x_axis_z, y_axis_x, y_axis_y,
                  y_axis_z, z_axis_x, z_axis_y, z_axis_z, output ready);
endinterface

interface rmq_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [rmq_pkg::IO_W-1:0]    quat_w;
  logic signed [rmq_pkg::IO_W-1:0]    quat_x;
  logic signed [rmq_pkg::IO_W-1:0]    quat_y;
  logic signed [rmq_pkg::IO_W-1:0]    quat_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

### rtl/core/rmq_front.sv
// ----------------------------------------------------------------------------
// rmq_front
// Branch select, component vector, squares and sum of squares (three stages)
// ----------------------------------------------------------------------------
module rmq_front #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         valid_i,
  input  rmq_pkg::mat_t                mat_i,
  output logic                         valid_o,
  output logic [2*rmq_pkg::vec_w(FRAC_BITS)+1:0] m2_o,
  output logic signed [rmq_pkg::vec_w(FRAC_BITS)-1:0] vec_o [4]
);

  localparam int VW = rmq_pkg::vec_w(FRAC_BITS);
  localparam int SW = 2 * VW;
  localparam int MW = SW + 2;
  localparam logic signed [VW-1:0] ONE = VW'(64'(1) << FRAC_BITS);

  logic signed [VW-1:0] xx, xy, xz, yx, yy, yz, zx, zy, zz, tr, rad;
  logic signed [VW-1:0] vec_nxt [4];
  logic signed [VW-1:0] vec1_r [4];
  logic signed [VW-1:0] vec2_r [4];
  logic signed [VW-1:0] vec3_r [4];
  logic        [SW-1:0] sq_r [4];
  logic        [MW-1:0] m2_r;
  logic                 v1_r, v2_r, v3_r;

  always_comb begin
    xx = VW'(mat_i.x_axis_x); xy = VW'(mat_i.x_axis_y); xz = VW'(mat_i.x_axis_z);
    yx = VW'(mat_i.y_axis_x); yy = VW'(mat_i.y_axis_y); yz = VW'(mat_i.y_axis_z);
    zx = VW'(mat_i.z_axis_x); zy = VW'(mat_i.z_axis_y); zz = VW'(mat_i.z_axis_z);
    tr = xx + yy + zz;
    if (tr > 0) begin
      rad = ONE + tr;
      if (rad <= 0) rad = VW'(1);
      vec_nxt[0] = rad;     vec_nxt[1] = zy - yz;
      vec_nxt[2] = xz - zx; vec_nxt[3] = yx - xy;
    end else if (xx > yy && xx > zz) begin
      rad = ONE + xx - yy - zz;
      if (rad <= 0) rad = VW'(1);
      vec_nxt[0] = zy - yz; vec_nxt[1] = rad;
      vec_nxt[2] = xy + yx; vec_nxt[3] = xz + zx;
    end else if (yy > zz) begin
      rad = ONE + yy - xx - zz;
      if (rad <= 0) rad = VW'(1);
      vec_nxt[0] = xz - zx; vec_nxt[1] = xy + yx;
      vec_nxt[2] = rad;     vec_nxt[3] = yz + zy;
    end else begin
      rad = ONE + zz - xx - yy;
      if (rad <= 0) rad = VW'(1);
      vec_nxt[0] = yx - xy; vec_nxt[1] = xz + zx;
      vec_nxt[2] = yz + zy; vec_nxt[3] = rad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= valid_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        vec1_r[i] <= vec_nxt[i];
        vec2_r[i] <= vec1_r[i];
        vec3_r[i] <= vec2_r[i];
        sq_r[i]   <= SW'(unsigned'(vec1_r[i] < 0 ? -vec1_r[i] : vec1_r[i]))
                   * SW'(unsigned'(vec1_r[i] < 0 ? -vec1_r[i] : vec1_r[i]));
      end
      m2_r <= MW'(sq_r[0]) + MW'(sq_r[1]) + MW'(sq_r[2]) + MW'(sq_r[3]);
    end
  end

  assign valid_o = v3_r;
  assign m2_o    = m2_r;
  assign vec_o   = vec3_r;

endmodule

### rtl/core/rmq_sqrt.sv
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root, one result bit per stage, with sideband
// ----------------------------------------------------------------------------
module rmq_sqrt #(
  parameter int W   = 46,
  parameter int SBW = 88
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 valid_i,
  input  logic [W-1:0]         rad_i,
  input  logic [SBW-1:0]       sb_i,
  output logic                 valid_o,
  output logic [(W+1)/2-1:0]   root_o,
  output logic [SBW-1:0]       sb_o
);

  localparam int STEPS = (W + 1) / 2;

  logic [W-1:0]   rem_r [STEPS];
  logic [W-1:0]   res_r [STEPS];
  logic [SBW-1:0] sb_r  [STEPS];
  logic           v_r   [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_st
    localparam logic [W-1:0] BIT = W'(1) << (2 * (STEPS - 1 - k));
    logic [W-1:0]   rem_in, res_in, trial;
    logic [SBW-1:0] sb_in;
    logic           v_in;

    if (k == 0) begin : g_first
      assign rem_in = rad_i;
      assign res_in = '0;
      assign sb_in  = sb_i;
      assign v_in   = valid_i;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign res_in = res_r[k-1];
      assign sb_in  = sb_r[k-1];
      assign v_in   = v_r[k-1];
    end

    assign trial = res_in + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sb_r[k] <= sb_in;
        if (rem_in >= trial) begin
          rem_r[k] <= rem_in - trial;
          res_r[k] <= (res_in >> 1) + BIT;
        end else begin
          rem_r[k] <= rem_in;
          res_r[k] <= res_in >> 1;
        end
      end
    end
  end

  assign valid_o = v_r[STEPS-1];
  assign root_o  = res_r[STEPS-1][STEPS-1:0];
  assign sb_o    = sb_r[STEPS-1];

endmodule

### rtl/core/rmq_div.sv
// ----------------------------------------------------------------------------
// rmq_div
// Pipelined rounded divide of one component by the length, one quotient bit
// per stage, then saturation and sign
// ----------------------------------------------------------------------------
module rmq_div #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
  parameter int MAGW      = 22,
  parameter int LENW      = 23
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              valid_i,
  input  logic [MAGW-1:0]                   mag_i,
  input  logic [LENW-1:0]                   len_i,
  input  logic                              neg_i,
  output logic                              valid_o,
  output logic signed [rmq_pkg::IO_W-1:0]   q_o
);

  localparam int NW    = MAGW + FRAC_BITS + 1;
  localparam int QW    = FRAC_BITS + 1;
  localparam int STEPS = FRAC_BITS + 1;
  localparam logic [QW-1:0] LIM_Q = QW'(rmq_pkg::lim_val(FRAC_BITS));

  logic [NW-1:0]   rem_r [STEPS];
  logic [LENW-1:0] len_r [STEPS];
  logic [QW-1:0]   q_r   [STEPS];
  logic            neg_r [STEPS];
  logic            v_r   [STEPS];

  logic [LENW-1:0]          len_g;
  logic [NW-1:0]            num;
  logic [QW-1:0]            sat;
  logic [rmq_pkg::IO_W-1:0] mag18;

  assign len_g = (len_i == '0) ? LENW'(1) : len_i;
  assign num   = (NW'(mag_i) << FRAC_BITS) + NW'(len_g >> 1);

  for (genvar j = 0; j < STEPS; j++) begin : g_st
    localparam int SH = FRAC_BITS - j;
    logic [NW-1:0]   rem_in, dsh;
    logic [LENW-1:0] len_in;
    logic [QW-1:0]   q_in;
    logic            neg_in, v_in;

    if (j == 0) begin : g_first
      assign rem_in = num;
      assign len_in = len_g;
      assign q_in   = '0;
      assign neg_in = neg_i;
      assign v_in   = valid_i;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign len_in = len_r[j-1];
      assign q_in   = q_r[j-1];
      assign neg_in = neg_r[j-1];
      assign v_in   = v_r[j-1];
    end

    assign dsh = NW'(len_in) << SH;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        len_r[j] <= len_in;
        neg_r[j] <= neg_in;
        if (rem_in >= dsh) begin
          rem_r[j] <= rem_in - dsh;
          q_r[j]   <= q_in | (QW'(1) << SH);
        end else begin
          rem_r[j] <= rem_in;
          q_r[j]   <= q_in;
        end
      end
    end
  end

  assign sat     = (q_r[STEPS-1] > LIM_Q) ? LIM_Q : q_r[STEPS-1];
  assign mag18   = rmq_pkg::IO_W'(sat);
  assign q_o     = neg_r[STEPS-1] ? -signed'(mag18) : signed'(mag18);
  assign valid_o = v_r[STEPS-1];

endmodule

### rtl/core/rotation_matrix_to_quaternion.sv
// pipeline: front end, square root, dividers and an output register
// throughput: one matrix per cycle while the output is not stalled, set by a fully pipelined root and divider
// a stalled output freezes the whole pipeline, nothing is dropped or repeated
// reset: synchronous, active low, clears all valid bits; no stored state
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts a Q1.F rotation matrix into a conjugated unit quaternion
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rmq_in_if.sink     in_req,
  rmq_out_if.source  out_res
);

  localparam int VW  = rmq_pkg::vec_w(FRAC_BITS);
  localparam int MW  = 2 * VW + 2;
  localparam int LW  = (MW + 1) / 2;
  localparam int SBW = 4 * VW;
  localparam int LIM = rmq_pkg::lim_val(FRAC_BITS);

  logic                      adv;
  rmq_pkg::mat_t             mat;
  logic                      fr_valid, sq_valid;
  logic [MW-1:0]             fr_m2;
  logic signed [VW-1:0]      fr_vec [4];
  logic [SBW-1:0]            fr_sb, sq_sb;
  logic [LW-1:0]             sq_len;
  logic                      dv_valid [4];
  logic signed [rmq_pkg::IO_W-1:0] dv_q [4];
  logic                      out_valid_r;
  logic signed [rmq_pkg::IO_W-1:0] quat_r [4];

  assign adv          = !out_valid_r || out_res.ready;
  assign in_req.ready = adv;

  assign mat.x_axis_x = in_req.x_axis_x;
  assign mat.x_axis_y = in_req.x_axis_y;
  assign mat.x_axis_z = in_req.x_axis_z;
  assign mat.y_axis_x = in_req.y_axis_x;
  assign mat.y_axis_y = in_req.y_axis_y;
  assign mat.y_axis_z = in_req.y_axis_z;
  assign mat.z_axis_x = in_req.z_axis_x;
  assign mat.z_axis_y = in_req.z_axis_y;
  assign mat.z_axis_z = in_req.z_axis_z;

  rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .valid_i (in_req.valid),
    .mat_i   (mat),
    .valid_o (fr_valid),
    .m2_o    (fr_m2),
    .vec_o   (fr_vec)
  );

  assign fr_sb = {fr_vec[3], fr_vec[2], fr_vec[1], fr_vec[0]};

  rmq_sqrt #(.W(MW), .SBW(SBW)) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .valid_i (fr_valid),
    .rad_i   (fr_m2),
    .sb_i    (fr_sb),
    .valid_o (sq_valid),
    .root_o  (sq_len),
    .sb_o    (sq_sb)
  );

  for (genvar i = 0; i < 4; i++) begin : g_lane
    logic signed [VW-1:0] comp;
    logic [VW-1:0]        mag;
    logic                 neg;

    assign comp = signed'(sq_sb[i*VW +: VW]);
    assign mag  = unsigned'(comp < 0 ? -comp : comp);
    // vector part is negated for the conjugate
    assign neg  = (comp < 0) ^ (i != 0);

    rmq_div #(.FRAC_BITS(FRAC_BITS), .MAGW(VW), .LENW(LW)) u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .valid_i (sq_valid),
      .mag_i   (mag),
      .len_i   (sq_len),
      .neg_i   (neg),
      .valid_o (dv_valid[i]),
      .q_o     (dv_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_valid[0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      quat_r <= dv_q;
    end
  end

  assign out_res.valid  = out_valid_r;
  assign out_res.quat_w = quat_r[0];
  assign out_res.quat_x = quat_r[1];
  assign out_res.quat_y = quat_r[2];
  assign out_res.quat_z = quat_r[3];

`ifndef SYNTHESIS
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res.ready) |-> !in_req.ready)
    else $error("input taken while output stalled");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    sq_valid |-> (sq_len != '0))
    else $error("zero length from root");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_valid[0] == dv_valid[1]) && (dv_valid[0] == dv_valid[2]) &&
    (dv_valid[0] == dv_valid[3]))
    else $error("divider lanes out of step");

  a_w_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (int'(quat_r[0]) <= LIM && int'(quat_r[0]) >= -LIM))
    else $error("scalar part out of range");
`endif

endmodule

### test/tb_rotation_matrix_to_quaternion.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion
// Drives matrices into the converter and checks every quaternion against a
// local Shepperd predictor, with random idling on both sides and back pressure
// ----------------------------------------------------------------------------
module tb_rotation_matrix_to_quaternion;

  localparam int FB = 16;
  localparam int IOW = rmq_pkg::IO_W;
  localparam int ONE = 1 << FB;
  localparam int LAT = 44;
  localparam longint LIMIT = 400000;

  typedef struct packed {
    logic signed [IOW-1:0] w;
    logic signed [IOW-1:0] x;
    logic signed [IOW-1:0] y;
    logic signed [IOW-1:0] z;
  } quat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rmq_in_if  in_req();
  rmq_out_if out_res();

  rotation_matrix_to_quaternion #(.FRAC_BITS(FB)) uut (
    .clk(clk), .rst_n(rst_n), .in_req(in_req.sink), .out_res(out_res.source)
  );

  always #6 clk = ~clk;

  rmq_pkg::mat_t pending_mats[$];
  quat_t  expected_quats[$];
  int     errors = 0;
  int     n_rx = 0;
  longint cycle = 0;
  bit     idle_on = 1'b1;
  int     hold_off = 0;
  int     src_gap = 0;
  int     snk_gap = 0;
  int     branch_cnt[4];

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [IOW-1:0] scale(longint v, longint unsigned len, bit neg);
    longint unsigned a, q;
    longint s;
    a = (v < 0) ? -v : v;
    q = ((a << FB) + (len >> 1)) / len;
    s = (q > ONE) ? longint'(ONE) : longint'(q);
    if ((v < 0) != neg) s = -s;
    return s[IOW-1:0];
  endfunction

  function automatic quat_t predict_quat(rmq_pkg::mat_t m);
    longint xx, xy, xz, yx, yy, yz, zx, zy, zz, t, r, w, x, y, z;
    longint unsigned m2, len;
    quat_t q;
    xx = longint'(m.x_axis_x); xy = longint'(m.x_axis_y); xz = longint'(m.x_axis_z);
    yx = longint'(m.y_axis_x); yy = longint'(m.y_axis_y); yz = longint'(m.y_axis_z);
    zx = longint'(m.z_axis_x); zy = longint'(m.z_axis_y); zz = longint'(m.z_axis_z);
    t = xx + yy + zz;
    if (t > 0) begin
      r = ONE + t; if (r <= 0) r = 1;
      w = r; x = zy - yz; y = xz - zx; z = yx - xy;
      branch_cnt[0]++;
    end else if (xx > yy && xx > zz) begin
      r = ONE + xx - yy - zz; if (r <= 0) r = 1;
      w = zy - yz; x = r; y = xy + yx; z = xz + zx;
      branch_cnt[1]++;
    end else if (yy > zz) begin
      r = ONE + yy - xx - zz; if (r <= 0) r = 1;
      w = xz - zx; x = xy + yx; y = r; z = yz + zy;
      branch_cnt[2]++;
    end else begin
      r = ONE + zz - xx - yy; if (r <= 0) r = 1;
      w = yx - xy; x = xz + zx; y = yz + zy; z = r;
      branch_cnt[3]++;
    end
    m2 = w * w + x * x + y * y + z * z;
    len = root64(m2);
    if (len == 0) len = 1;
    q.w = scale(w, len, 1'b0);
    q.x = scale(x, len, 1'b1);
    q.y = scale(y, len, 1'b1);
    q.z = scale(z, len, 1'b1);
    return q;
  endfunction

  // full 18-bit range, biased towards the Q1.16 range and its extremes
  function automatic logic [IOW-1:0] rand_elem();
    int k;
    k = int'($urandom_range(0, 9));
    if (k == 0) return IOW'($urandom());
    if (k == 1) return IOW'(ONE - int'($urandom_range(0, 3)));
    if (k == 2) return IOW'(-(ONE - int'($urandom_range(0, 3))));
    return IOW'(int'($urandom_range(0, 2 * ONE)) - ONE);
  endfunction

  function automatic rmq_pkg::mat_t rand_mat();
    rmq_pkg::mat_t m;
    int k;
    m = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
         rand_elem(), rand_elem(), rand_elem(), rand_elem()};
    k = int'($urandom_range(0, 3));
    // steer diagonals so every branch and diagonal ties get exercised
    if (k == 1) m.x_axis_x = IOW'(ONE - int'($urandom_range(0, 20000)));
    if (k == 2) m.y_axis_y = m.z_axis_z;
    if (k == 3) m.x_axis_x = m.y_axis_y;
    return m;
  endfunction

  function automatic rmq_pkg::mat_t diag(int a, int b, int c);
    rmq_pkg::mat_t m;
    m = '0;
    m.x_axis_x = IOW'(a); m.y_axis_y = IOW'(b); m.z_axis_z = IOW'(c);
    return m;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_req.valid <= 1'b0;
    end else begin
      if (in_req.valid && in_req.ready) begin
        expected_quats.push_back(predict_quat({in_req.x_axis_x, in_req.x_axis_y,
          in_req.x_axis_z, in_req.y_axis_x, in_req.y_axis_y, in_req.y_axis_z,
          in_req.z_axis_x, in_req.z_axis_y, in_req.z_axis_z}));
      end
      if (in_req.valid && !in_req.ready) begin
        // hold the request
      end else if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        in_req.valid <= 1'b0;
      end else if (pending_mats.size() > 0 &&
                   (!idle_on || $urandom_range(0, 7) != 0)) begin
        {in_req.x_axis_x, in_req.x_axis_y, in_req.x_axis_z, in_req.y_axis_x,
         in_req.y_axis_y, in_req.y_axis_z, in_req.z_axis_x, in_req.z_axis_y,
         in_req.z_axis_z} <= pending_mats.pop_front();
        in_req.valid <= 1'b1;
      end else begin
        in_req.valid <= 1'b0;
        if (idle_on && pending_mats.size() > 0) src_gap <= int'($urandom_range(0, 8));
      end
    end
  end

  // receiver ready with bursts of stall and one long hold-off
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (!rst_n) begin
      out_res.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_res.ready <= 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap <= snk_gap - 1;
      out_res.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      snk_gap <= int'($urandom_range(0, 8));
      out_res.ready <= 1'b0;
    end else begin
      out_res.ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    quat_t e;
    if (rst_n && out_res.valid && out_res.ready) begin
      n_rx++;
      if (expected_quats.size() == 0) begin
        $error("unexpected quaternion w=%0d", out_res.quat_w);
        errors++;
      end else begin
        e = expected_quats.pop_front();
        if (out_res.quat_w !== e.w) begin
          $error("quat_w expected %0d actual %0d", e.w, out_res.quat_w); errors++;
        end
        if (out_res.quat_x !== e.x) begin
          $error("quat_x expected %0d actual %0d", e.x, out_res.quat_x); errors++;
        end
        if (out_res.quat_y !== e.y) begin
          $error("quat_y expected %0d actual %0d", e.y, out_res.quat_y); errors++;
        end
        if (out_res.quat_z !== e.z) begin
          $error("quat_z expected %0d actual %0d", e.z, out_res.quat_z); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rmq_pkg::mat_t m;
    in_req.valid = 1'b0;
    {in_req.x_axis_x, in_req.x_axis_y, in_req.x_axis_z, in_req.y_axis_x,
     in_req.y_axis_y, in_req.y_axis_z, in_req.z_axis_x, in_req.z_axis_y,
     in_req.z_axis_z} = '0;
    out_res.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: identity, each branch, ties, clamped radicand, extremes
    pending_mats.push_back(diag(ONE, ONE, ONE));
    pending_mats.push_back(diag(ONE, -ONE, -ONE));
    pending_mats.push_back(diag(-ONE, ONE, -ONE));
    pending_mats.push_back(diag(-ONE, -ONE, ONE));
    pending_mats.push_back(diag(0, 0, 0));
    pending_mats.push_back(diag(-ONE, -ONE, -ONE));
    pending_mats.push_back(diag(-ONE, -ONE, -ONE + 1));
    pending_mats.push_back(diag(-ONE, ONE, ONE) ^ '0);
    pending_mats.push_back(diag(-131072, -131072, -131072));
    pending_mats.push_back(diag(131071, 131071, 131071));
    pending_mats.push_back(diag(1000, 1000, -5000));
    m = '1; pending_mats.push_back(m);
    m = '0;
    m.x_axis_y = IOW'(131071); m.y_axis_x = IOW'(131071);
    m.z_axis_y = IOW'(-131072); m.y_axis_z = IOW'(131071);
    pending_mats.push_back(m);
    m = {9{18'sh1FFFF}}; pending_mats.push_back(m);
    m = {9{18'sh20000}}; pending_mats.push_back(m);
    m = '0; m.y_axis_x = IOW'(ONE); m.x_axis_y = IOW'(-ONE); m.z_axis_z = IOW'(ONE);
    pending_mats.push_back(m);
    m = '0; m.x_axis_z = IOW'(ONE); m.z_axis_x = IOW'(ONE); m.y_axis_y = IOW'(-ONE);
    pending_mats.push_back(m);
    m = '0; m.y_axis_z = IOW'(-ONE); m.z_axis_y = IOW'(-ONE); m.x_axis_x = IOW'(-ONE);
    pending_mats.push_back(m);
    for (int i = 0; i < 500; i++) pending_mats.push_back(rand_mat());
    wait (pending_mats.size() == 0);

    // long receiver hold-off while the sender keeps offering
    hold_off = 300;
    for (int i = 0; i < 300; i++) pending_mats.push_back(rand_mat());
    wait (pending_mats.size() == 0 && expected_quats.size() == 0 && !in_req.valid);
    // sender paused until all results came back
    for (int i = 0; i < 500; i++) pending_mats.push_back(rand_mat());
    wait (pending_mats.size() < 20);
    idle_on = 1'b0;
    for (int i = 0; i < 300; i++) pending_mats.push_back(rand_mat());
    wait (pending_mats.size() == 0);
    @(posedge clk);
    wait (!in_req.valid || in_req.ready);
    @(posedge clk);
    wait (expected_quats.size() == 0);
    repeat (LAT + 10) @(posedge clk);
    $display("run covered %0d quaternions; branches w/x/y/z: %0d %0d %0d %0d",
             n_rx, branch_cnt[0], branch_cnt[1], branch_cnt[2], branch_cnt[3]);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
